// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, quiet while rst is high.
`define CD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define CD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cdisp_pkg.sv =====
// ----------------------------------------------------------------------------
// cdisp_pkg
// Codes, field widths and reset values for the connection dispatcher.
// ----------------------------------------------------------------------------
package cdisp_pkg;

  localparam int IDX_BITS    = 3;
  localparam int STATUS_BITS = 3;
  localparam int LOAD_BITS   = 8;
  localparam int LIMIT_BITS  = 8;
  localparam int MASK_BITS   = 8;
  localparam int THR_BITS    = 64;
  localparam int CFG_IDX_BITS = 2;

  // Command codes
  localparam logic CMD_DISPATCH = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  // Mode codes
  localparam logic MODE_LEAST = 1'b0;
  localparam logic MODE_RR    = 1'b1;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_REJECTED  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_NO_ACTIVE = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_COMPLETED = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_IGNORED   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE        = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_MASK = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLDS  = 2'd2;

  // Reset values of the configuration registers
  localparam logic                 MODE_RESET   = MODE_LEAST;
  localparam logic [MASK_BITS-1:0] MASK_RESET   = 8'h07;
  localparam logic [THR_BITS-1:0]  THR_RESET    = 64'h0303_0303_0303_0303;

endpackage

// ===== hw/rtl/connection_dispatcher.sv =====
// ----------------------------------------------------------------------------
// connection_dispatcher
// Least-connection / round-robin request dispatcher with per-destination
// in-service counters and limits.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. cmd
//   selects dispatch (pick a destination) or completion (dest_index finished
//   one request). The request lands in an input register, the pick and the
//   counter update are done in the following cycle, and the answer is
//   registered: done rises at the next edge and stays high for one cycle with
//   chosen, status and load_now. One request per cycle is sustained; the
//   counters are updated at the same edge that loads the result, so the next
//   request already sees them.
//   Configuration (mode, active_mask, thresholds) is written through
//   cfg_write / cfg_index / cfg_data while no request is in flight; unknown
//   indexes are dropped.
//   rst (synchronous) clears all counters, the round-robin pointer and the
//   pipeline, restores register defaults, and holds busy high during reset.
//   The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module connection_dispatcher #(
  parameter int DESTINATIONS = 8,
  parameter int COUNT_BITS   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cmd,
  input  logic [cdisp_pkg::IDX_BITS-1:0]       dest_index,
  input  logic                                 cfg_write,
  input  logic [cdisp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [cdisp_pkg::THR_BITS-1:0]       cfg_data,
  output logic                                 done,
  output logic [cdisp_pkg::IDX_BITS-1:0]       chosen,
  output logic [cdisp_pkg::STATUS_BITS-1:0]    status,
  output logic [cdisp_pkg::LOAD_BITS-1:0]      load_now
);

  localparam int DW = (DESTINATIONS > 1) ? $clog2(DESTINATIONS) : 1;
  localparam int CMP_BITS = (COUNT_BITS > cdisp_pkg::LIMIT_BITS) ?
                            COUNT_BITS + 1 : cdisp_pkg::LIMIT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers
  logic                                mode;
  logic [cdisp_pkg::MASK_BITS-1:0]     active_mask;
  logic [cdisp_pkg::THR_BITS-1:0]      thresholds;

  // State
  logic [COUNT_BITS-1:0] in_service [DESTINATIONS];
  logic [DW-1:0]         rr_next;

  // Input register
  logic                            in_valid;
  logic                            in_cmd;
  logic [cdisp_pkg::IDX_BITS-1:0]  in_dest;

  // Work signals
  logic [DESTINATIONS-1:0]         act;
  logic [cdisp_pkg::LIMIT_BITS-1:0] limit [DESTINATIONS];
  logic                            lc_found;
  logic [DW-1:0]                   lc_pick;
  logic                            rr_found;
  logic [DW-1:0]                   rr_pick;
  logic [3:0]                      rr_sum;
  logic [DW-1:0]                   rr_c;
  logic                            found;
  logic [DW-1:0]                   pick;
  logic [DW-1:0]                   cidx;
  logic [COUNT_BITS-1:0]           cur;
  logic                            upd_en;
  logic [DW-1:0]                   upd_idx;
  logic [COUNT_BITS-1:0]           upd_val;
  logic [DW-1:0]                   rr_next_next;
  logic [cdisp_pkg::IDX_BITS-1:0]  chosen_next;
  logic [cdisp_pkg::STATUS_BITS-1:0] status_next;
  logic [COUNT_BITS-1:0]           load_next;

  always_comb begin
    act = active_mask[DESTINATIONS-1:0];
    for (int d = 0; d < DESTINATIONS; d++) begin
      limit[d] = thresholds[d*cdisp_pkg::LIMIT_BITS +: cdisp_pkg::LIMIT_BITS];
    end
  end

  // Least-connection: lowest count among active, ties to lowest index
  always_comb begin
    lc_found = 1'b0;
    lc_pick  = '0;
    for (int i = 0; i < DESTINATIONS; i++) begin
      if (act[i] && (!lc_found || in_service[i] < in_service[lc_pick])) begin
        lc_pick  = DW'(i);
        lc_found = 1'b1;
      end
    end
  end

  // Round-robin: first active at or after rr_next, wrapping
  always_comb begin
    rr_found = 1'b0;
    rr_pick  = '0;
    rr_sum   = '0;
    rr_c     = '0;
    for (int i = 0; i < DESTINATIONS; i++) begin
      rr_sum = 4'(rr_next) + 4'(i);
      if (32'(rr_sum) >= DESTINATIONS) begin
        rr_sum = rr_sum - 4'(DESTINATIONS);
      end
      rr_c = DW'(rr_sum);
      if (!rr_found && act[rr_c]) begin
        rr_pick  = rr_c;
        rr_found = 1'b1;
      end
    end
  end

  always_comb begin
    found = (mode == cdisp_pkg::MODE_RR) ? rr_found : lc_found;
    pick  = (mode == cdisp_pkg::MODE_RR) ? rr_pick : lc_pick;
    cidx  = DW'(in_dest);
    cur   = in_service[pick];

    upd_en       = 1'b0;
    upd_idx      = pick;
    upd_val      = cur;
    rr_next_next = rr_next;
    chosen_next  = cdisp_pkg::IDX_BITS'(pick);
    status_next  = cdisp_pkg::ST_NO_ACTIVE;
    load_next    = '0;

    if (in_cmd == cdisp_pkg::CMD_COMPLETE) begin
      chosen_next = in_dest;
      status_next = cdisp_pkg::ST_IGNORED;
      if (32'(in_dest) < DESTINATIONS) begin
        upd_idx   = cidx;
        load_next = in_service[cidx];
        if (in_service[cidx] != '0) begin
          upd_en      = 1'b1;
          upd_val     = in_service[cidx] - 1'b1;
          load_next   = upd_val;
          status_next = cdisp_pkg::ST_COMPLETED;
        end
      end
    end else if (!found) begin
      chosen_next = '0;
    end else begin
      if (mode == cdisp_pkg::MODE_RR) begin
        rr_next_next = (32'(pick) == DESTINATIONS - 1) ? '0 : pick + 1'b1;
      end
      load_next   = cur;
      status_next = cdisp_pkg::ST_REJECTED;
      if (CMP_BITS'(cur) < CMP_BITS'(limit[pick]) && cur != COUNT_MAX) begin
        upd_en      = 1'b1;
        upd_val     = cur + 1'b1;
        load_next   = upd_val;
        status_next = cdisp_pkg::ST_ACCEPTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      in_valid    <= 1'b0;
      done        <= 1'b0;
      rr_next     <= '0;
      mode        <= cdisp_pkg::MODE_RESET;
      active_mask <= cdisp_pkg::MASK_RESET;
      thresholds  <= cdisp_pkg::THR_RESET;
      for (int d = 0; d < DESTINATIONS; d++) begin
        in_service[d] <= '0;
      end
    end else begin
      busy     <= 1'b0;
      in_valid <= start && !busy;
      done     <= in_valid;
      if (cfg_write) begin
        case (cfg_index)
          cdisp_pkg::REG_MODE:        mode        <= cfg_data[0];
          cdisp_pkg::REG_ACTIVE_MASK: active_mask <= cfg_data[cdisp_pkg::MASK_BITS-1:0];
          cdisp_pkg::REG_THRESHOLDS:  thresholds  <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid) begin
        rr_next <= rr_next_next;
        if (upd_en) begin
          in_service[upd_idx] <= upd_val;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd  <= cmd;
      in_dest <= dest_index;
    end
    if (in_valid) begin
      chosen   <= chosen_next;
      status   <= status_next;
      load_now <= cdisp_pkg::LOAD_BITS'(load_next);
    end
  end

  `CD_ASSERT(a_result_follows, (start && !busy) |-> ##2 done, "request produced no result")
  `CD_ASSERT(a_result_has_request, done |-> ($past(start && !busy, 2)), "result without request")
  `CD_ASSERT(a_no_active_shape, (done && status == cdisp_pkg::ST_NO_ACTIVE) |-> (chosen == '0 && load_now == '0), "no-active result not zeroed")
  `CD_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !done, "result right after reset")

endmodule

// ===== dv/connection_dispatcher_tb.sv =====
// ----------------------------------------------------------------------------
// connection_dispatcher_tb
// Self-checking bench for the connection dispatcher. It drives dispatch and
// completion requests under changing mode, active mask and limit settings,
// predicts each answer from a local copy of the per-destination counters and
// the round-robin pointer, and compares every answer field by field.
// ----------------------------------------------------------------------------
module connection_dispatcher_tb;
  import cdisp_pkg::*;

  localparam int                      LIMIT_CYCLES   = 200000;
  localparam int                      PHASE_REQUESTS = 160;
  localparam int                      MAX_REPORTS    = 30;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED     = 2'd3;

  // Predicted answers and the dispatcher state behind them.
  class dispatch_scoreboard;
    typedef struct packed {
      logic [IDX_BITS-1:0]    chosen;
      logic [STATUS_BITS-1:0] status;
      logic [LOAD_BITS-1:0]   load;
    } answer_t;

    logic                  mode;
    logic [MASK_BITS-1:0]  mask;
    logic [THR_BITS-1:0]   limits;
    logic [LOAD_BITS-1:0]  in_service [8];
    logic [IDX_BITS-1:0]   rr_ptr;
    answer_t               answer_q [$];
    int                    errors;
    int                    requests;
    int                    status_seen [5];

    function new();
      mode   = MODE_RESET;
      mask   = MASK_RESET;
      limits = THR_RESET;
      rr_ptr = '0;
      foreach (in_service[i]) in_service[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      errors   = 0;
      requests = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [THR_BITS-1:0] data);
      case (idx)
        REG_MODE:        mode   = data[0];
        REG_ACTIVE_MASK: mask   = data[MASK_BITS-1:0];
        REG_THRESHOLDS:  limits = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return answer_q.size();
    endfunction

    function void note_request(logic c, logic [IDX_BITS-1:0] d);
      answer_t a;
      logic    found;
      logic [IDX_BITS-1:0] pick;
      logic [IDX_BITS-1:0] cand;
      a     = '0;
      found = 1'b0;
      pick  = '0;
      requests++;
      if (c == CMD_COMPLETE) begin
        a.chosen = d;
        if (in_service[d] != 0) begin
          in_service[d] = in_service[d] - 1'b1;
          a.status = ST_COMPLETED;
        end else begin
          a.status = ST_IGNORED;
        end
        a.load = in_service[d];
      end else begin
        if (mode == MODE_LEAST) begin
          for (int i = 0; i < 8; i++) begin
            if (mask[i] && (!found || in_service[i] < in_service[pick])) begin
              pick  = i[IDX_BITS-1:0];
              found = 1'b1;
            end
          end
        end else begin
          for (int k = 0; k < 8 && !found; k++) begin
            cand = rr_ptr + k[IDX_BITS-1:0];
            if (mask[cand]) begin
              pick  = cand;
              found = 1'b1;
            end
          end
          if (found) rr_ptr = pick + 1'b1;
        end
        if (!found) begin
          a.chosen = '0;
          a.status = ST_NO_ACTIVE;
          a.load   = '0;
        end else begin
          a.chosen = pick;
          // a full counter rejects even under a higher limit
          if (in_service[pick] < limits[8*pick +: LIMIT_BITS] &&
              in_service[pick] != {LOAD_BITS{1'b1}}) begin
            in_service[pick] = in_service[pick] + 1'b1;
            a.status = ST_ACCEPTED;
          end else begin
            a.status = ST_REJECTED;
          end
          a.load = in_service[pick];
        end
      end
      status_seen[a.status]++;
      answer_q.push_back(a);
    endfunction

    function void report(string field, int exp_val, int act_val);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
                 act_val);
    endfunction

    function void check_result(logic [IDX_BITS-1:0] ch, logic [STATUS_BITS-1:0] st,
                               logic [LOAD_BITS-1:0] ld);
      answer_t a;
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected answer, expected none, actual chosen %0d status %0d load %0d",
                   $time, ch, st, ld);
        return;
      end
      a = answer_q.pop_front();
      if (ch !== a.chosen) report("chosen", a.chosen, ch);
      if (st !== a.status) report("status", a.status, st);
      if (ld !== a.load)   report("load_now", a.load, ld);
    endfunction
  endclass

  logic                    clk;
  logic                    rst        = 1'b1;
  logic                    start      = 1'b0;
  logic                    cmd        = CMD_DISPATCH;
  logic [IDX_BITS-1:0]     dest_index = '0;
  logic                    cfg_write  = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index  = REG_MODE;
  logic [THR_BITS-1:0]     cfg_data   = '0;
  logic                    busy;
  logic                    done;
  logic [IDX_BITS-1:0]     chosen;
  logic [STATUS_BITS-1:0]  status;
  logic [LOAD_BITS-1:0]    load_now;

  dispatch_scoreboard sb;
  int                 cycles = 0;

  connection_dispatcher u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .dest_index(dest_index),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .chosen    (chosen),
    .status    (status),
    .load_now  (load_now)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(chosen, status, load_now);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d answers outstanding", $time, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Holds the request until the edge that takes it; start stays high afterward.
  task automatic send_request(input logic c, input logic [IDX_BITS-1:0] d, input int idle_pct);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    cmd        <= c;
    dest_index <= d;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(c, d);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [THR_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Upper data bits carry junk to check that narrow registers drop them.
  task automatic program_regs(input logic m, input logic [MASK_BITS-1:0] msk,
                              input logic [THR_BITS-1:0] thr);
    logic [THR_BITS-1:0] junk;
    junk = {$urandom, $urandom};
    put_reg(REG_UNUSED, junk);
    junk = {$urandom, $urandom};
    junk[0] = m;
    put_reg(REG_MODE, junk);
    junk = {$urandom, $urandom};
    junk[MASK_BITS-1:0] = msk;
    put_reg(REG_ACTIVE_MASK, junk);
    put_reg(REG_THRESHOLDS, thr);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [THR_BITS-1:0] random_limits();
    logic [THR_BITS-1:0] thr;
    int                  r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(9);
      if (r == 0)      thr[8*i +: 8] = 8'h00;
      else if (r == 1) thr[8*i +: 8] = 8'hFF;
      else             thr[8*i +: 8] = 8'($urandom_range(1, 6));
    end
    return thr;
  endfunction

  function automatic logic [MASK_BITS-1:0] random_mask();
    case ($urandom_range(3))
      0:       return 8'hFF;
      1:       return 8'(1 << $urandom_range(7));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  initial begin
    int idle_pct;
    int dispatch_pct;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // Directed: default setup fills to the limit of 3, then overloads.
    for (int i = 0; i < 10; i++) send_request(CMD_DISPATCH, 3'($urandom), 0);
    send_request(CMD_COMPLETE, 3'd0, 0);
    send_request(CMD_COMPLETE, 3'd0, 0);
    send_request(CMD_COMPLETE, 3'd5, 0);  // zero count
    send_request(CMD_COMPLETE, 3'd7, 0);
    drain();
    // nothing active; inactive destination still counts down
    program_regs(MODE_RR, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_DISPATCH, 3'd0, 0);
    send_request(CMD_COMPLETE, 3'd1, 0);
    drain();
    // round-robin wrap over the two end destinations
    program_regs(MODE_RR, 8'h81, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 3; i++) send_request(CMD_DISPATCH, 3'd7, 0);
    drain();
    // zero limits reject everything
    program_regs(MODE_LEAST, 8'hFF, 64'h0);
    send_request(CMD_DISPATCH, 3'd0, 0);
    send_request(CMD_DISPATCH, 3'd3, 0);
    drain();

    // Counter saturation: a limit of 255 still stops at the full count.
    program_regs(MODE_LEAST, 8'h01, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 257; i++) send_request(CMD_DISPATCH, 3'($urandom), 18);
    send_request(CMD_COMPLETE, 3'd0, 18);
    drain();

    // Random phases, alternating mode and sender idling.
    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 46;
        default: idle_pct = 18;
      endcase
      if (p == 3) idle_pct = 46;
      if (p == 4) idle_pct = 0;
      program_regs(p[0] ? MODE_RR : MODE_LEAST, random_mask(), random_limits());
      dispatch_pct = $urandom_range(50, 65);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if ($urandom_range(199) == 0) drain();
        send_request(($urandom_range(99) < dispatch_pct) ? CMD_DISPATCH : CMD_COMPLETE,
                     3'($urandom), idle_pct);
      end
      drain();
    end

    repeat (6) @(posedge clk);
    $display("Covered %0d requests in both modes: %0d accepted, %0d overloaded, %0d no target,",
             sb.requests, sb.status_seen[ST_ACCEPTED], sb.status_seen[ST_REJECTED],
             sb.status_seen[ST_NO_ACTIVE]);
    $display("  %0d completions, %0d ignored completions; %0d check failures",
             sb.status_seen[ST_COMPLETED], sb.status_seen[ST_IGNORED], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
